### src/page_bitmap_allocator_with_chains_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page allocator
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_ALLOCATOR_WITH_CHAINS_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_WITH_CHAINS_DEFINES_SVH

// check outside reset only
`define PBAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define PBAC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pbac_pkg.sv
// ----------------------------------------------------------------------------
// pbac_pkg
// Shared types and codes of the page allocator with linked chains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbac_pkg;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_SET     = 2'd1,
    FN_RELEASE = 2'd2,
    FN_READ    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_RSV    = 2'd2,
    STAT_BOUND  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_WALK_VISIT,
    ST_WALK_NEXT,
    ST_LINK_WAIT,
    ST_FINISH
  } state_t;

  localparam int unsigned LINK_W   = 7;
  localparam int unsigned CNT_OUT_W = 8;
  localparam int unsigned GRP_BITS = 8;
  localparam int unsigned END_MARK = 2;

endpackage

`default_nettype wire

### src/page_bitmap_allocator_with_chains.sv
// Allocate scans one 8-page group a cycle (up to ceil(NUM_PAGES/8) groups); set-link
// goes to finish; read-link waits for the link read; release walks the chain.
// One item at a time: a shared group scanner and the single link read port set the pace.
// Output register holds a finished beat while the next item is accepted.
// Reset is synchronous and active low: link valid bits clear and pages below
// RESERVED_PAGES are marked used.
// ----------------------------------------------------------------------------
// page_bitmap_allocator_with_chains
// First-fit page allocator with a free map, per-page next links and chain release.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module page_bitmap_allocator_with_chains
  import pbac_pkg::*;
#(
  parameter int NUM_PAGES      = 128,
  parameter int RESERVED_PAGES = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // page_number[6:0], link_value[13:7], zero pad
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // result_page[6:0], result_link[13:7],
                                       // status[15:14], free_pages[23:16],
                                       // pages_released[31:24]
);

  localparam int PW       = $clog2(NUM_PAGES);
  localparam int CW       = $clog2(NUM_PAGES + 1);
  localparam int NG       = (NUM_PAGES + GRP_BITS - 1) / GRP_BITS;
  localparam int GW       = (NG > 1) ? $clog2(NG) : 1;
  localparam int MW       = NG * GRP_BITS;
  localparam int LOW_PAGE = (RESERVED_PAGES > END_MARK) ? RESERVED_PAGES : END_MARK;
  localparam logic [NUM_PAGES-1:0] MAP_INIT = {NUM_PAGES{1'b1}} << RESERVED_PAGES;

  function automatic logic walkable(input logic [LINK_W-1:0] v);
    return (32'(v) >= LOW_PAGE) && (32'(v) < NUM_PAGES);
  endfunction

  function automatic logic in_map(input logic [LINK_W-1:0] v);
    return 32'(v) < NUM_PAGES;
  endfunction

  state_t               state_r, state_nxt;
  logic [NUM_PAGES-1:0] free_map_r, free_map_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        steps_r, steps_nxt;
  logic [CW-1:0]        rel_r, rel_nxt;
  logic [GW-1:0]        grp_r, grp_nxt;
  logic [PW-1:0]        cur_r, cur_nxt;
  logic [LINK_W-1:0]    res_page_r, res_page_nxt;
  logic [LINK_W-1:0]    res_link_r, res_link_nxt;
  status_t              status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_data_r, out_data_nxt;

  logic                 accept;
  logic                 out_free;
  func_t                in_func;
  logic [LINK_W-1:0]    in_page;
  logic [LINK_W-1:0]    in_link;
  logic [MW-1:0]        map_pad;
  logic [GRP_BITS-1:0]  grp_word;
  logic [2:0]           pe;
  logic                 grp_hit;
  logic                 grp_last;
  logic [GW+2:0]        hit_idx;
  logic [PW-1:0]        alloc_page;

  logic                 lm_wr_en;
  logic                 lm_clr_en;
  logic [PW-1:0]        lm_wr_addr;
  logic [PW-1:0]        lm_rd_addr;
  logic [LINK_W-1:0]    link_q;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_func = func_t'(in_tuser);
  assign in_page = in_tdata[6:0];
  assign in_link = in_tdata[13:7];

  // first-fit scan, one group of eight pages a cycle
  assign map_pad  = MW'(free_map_r);
  assign grp_word = map_pad[{grp_r, 3'b000} +: GRP_BITS];
  assign grp_hit  = |grp_word;
  assign grp_last = (grp_r == GW'(NG - 1));

  always_comb begin
    pe = 3'd0;
    for (int i = GRP_BITS - 1; i >= 0; i--) begin
      if (grp_word[i]) begin
        pe = 3'(i);
      end
    end
  end

  assign hit_idx    = {grp_r, pe};
  assign alloc_page = PW'(hit_idx);

  assign lm_wr_en   = accept && (in_func == FN_SET) && walkable(in_page);
  assign lm_clr_en  = (state_r == ST_ALLOC) && grp_hit;
  assign lm_wr_addr = (state_r == ST_ALLOC) ? alloc_page : PW'(in_page);
  assign lm_rd_addr = (state_r == ST_IDLE) ? PW'(in_page) : cur_r;

  pbac_link_mem #(
    .NUM_PAGES (NUM_PAGES)
  ) u_link_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (lm_wr_en),
    .clr_en  (lm_clr_en),
    .wr_addr (lm_wr_addr),
    .wr_data (in_link),
    .rd_addr (lm_rd_addr),
    .rd_data (link_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FN_ALLOC:   state_nxt = ST_ALLOC;
            FN_SET:     state_nxt = ST_FINISH;
            FN_RELEASE: state_nxt = walkable(in_page) ? ST_WALK_VISIT : ST_FINISH;
            FN_READ:    state_nxt = in_map(in_page) ? ST_LINK_WAIT : ST_FINISH;
            default:    state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_ALLOC: begin
        if (grp_hit || grp_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_WALK_VISIT: state_nxt = ST_WALK_NEXT;
      ST_WALK_NEXT: begin
        if (!walkable(link_q) || (steps_r >= CW'(NUM_PAGES))) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_WALK_VISIT;
        end
      end
      ST_LINK_WAIT: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    free_map_nxt  = free_map_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    rel_nxt       = rel_r;
    grp_nxt       = grp_r;
    cur_nxt       = cur_r;
    res_page_nxt  = res_page_r;
    res_link_nxt  = res_link_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_page_nxt = '0;
          res_link_nxt = '0;
          rel_nxt      = '0;
          steps_nxt    = '0;
          grp_nxt      = '0;
          cur_nxt      = PW'(in_page);
          status_nxt   = STAT_OK;
          unique case (in_func)
            FN_ALLOC:   status_nxt = STAT_OK;
            FN_SET:     status_nxt = walkable(in_page) ? STAT_OK : STAT_RSV;
            FN_RELEASE: status_nxt = walkable(in_page) ? STAT_OK : STAT_RSV;
            FN_READ:    status_nxt = in_map(in_page) ? STAT_OK : STAT_RSV;
            default:    status_nxt = STAT_OK;
          endcase
        end
      end
      ST_ALLOC: begin
        if (grp_hit) begin
          free_map_nxt[alloc_page] = 1'b0;
          if (count_r != '0) begin
            count_nxt = count_r - CW'(1);
          end
          res_page_nxt = LINK_W'(hit_idx);
          status_nxt   = STAT_OK;
        end else if (grp_last) begin
          res_page_nxt = '0;
          status_nxt   = STAT_NOFREE;
        end else begin
          grp_nxt = grp_r + GW'(1);
        end
      end
      ST_WALK_VISIT: begin
        if (!free_map_r[cur_r]) begin
          free_map_nxt[cur_r] = 1'b1;
          count_nxt           = count_r + CW'(1);
          rel_nxt             = rel_r + CW'(1);
        end
        steps_nxt = steps_r + CW'(1);
      end
      ST_WALK_NEXT: begin
        if (walkable(link_q)) begin
          if (steps_r >= CW'(NUM_PAGES)) begin
            status_nxt = STAT_BOUND;
          end else begin
            cur_nxt = PW'(link_q);
          end
        end
      end
      ST_LINK_WAIT: begin
        res_link_nxt = link_q;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {CNT_OUT_W'(rel_r), CNT_OUT_W'(count_r), status_r,
                           res_link_r, res_page_r};
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_tready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_map_r  <= MAP_INIT;
      count_r     <= CW'(NUM_PAGES - RESERVED_PAGES);
      steps_r     <= '0;
      rel_r       <= '0;
      grp_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_map_r  <= free_map_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      rel_r       <= rel_nxt;
      grp_r       <= grp_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_page_r <= res_page_nxt;
    res_link_r <= res_link_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

### src/pbac_link_mem.sv
// ----------------------------------------------------------------------------
// pbac_link_mem
// Next-page link store: one write port, one registered read port, and a
// valid bit per page so that unwritten or cleared links read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbac_link_mem
  import pbac_pkg::*;
#(
  parameter int NUM_PAGES = 128
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic                         clr_en,
  input  wire logic [$clog2(NUM_PAGES)-1:0] wr_addr,
  input  wire logic [LINK_W-1:0]            wr_data,
  input  wire logic [$clog2(NUM_PAGES)-1:0] rd_addr,
  output logic      [LINK_W-1:0]            rd_data
);

  logic [LINK_W-1:0]    mem_r [NUM_PAGES];
  logic [NUM_PAGES-1:0] vld_r;
  logic [LINK_W-1:0]    rd_q_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end else if (clr_en) begin
        vld_r[wr_addr] <= 1'b0;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

### src/pbac_checker.sv
// ----------------------------------------------------------------------------
// pbac_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "page_bitmap_allocator_with_chains_defines.svh"

module pbac_checker
  import pbac_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  `PBAC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled output beat changed")
  `PBAC_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid, "output beat during reset")
  `PBAC_ASSERT(a_busy_after_in, in_tvalid && in_tready |=> !in_tready, "input taken while busy")
  `PBAC_ASSERT(a_nofree, out_tvalid && (out_tdata[15:14] == STAT_NOFREE) |-> (out_tdata[23:16] == 8'd0) && (out_tdata[6:0] == 7'd0), "no-free beat with free pages")
  `PBAC_ASSERT(a_rsv_quiet, out_tvalid && (out_tdata[15:14] == STAT_RSV) |-> (out_tdata[31:24] == 8'd0) && (out_tdata[6:0] == 7'd0), "reserved-page beat changed state")

endmodule

bind page_bitmap_allocator_with_chains pbac_checker u_pbac_checker (.*);

`default_nettype wire

### sim/page_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_alloc_checker
// Watches both streams of the page allocator, keeps its own free map, link
// table and free count, and compares every reply beat field by field.
// ----------------------------------------------------------------------------
module page_alloc_checker
  import pbac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // page_number[6:0], link_value[13:7], zero pad
  input  logic [1:0]  in_tuser,   // func[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // result_page[6:0], result_link[13:7],
                                  // status[15:14], free_pages[23:16],
                                  // pages_released[31:24]
  output int          fail_count,
  output int          outstanding,
  output int          replies_checked,
  output int          bound_walks,
  output int          empty_allocs
);

  localparam int PAGES      = 128;
  localparam int FIRST_FREE = 2;

  typedef struct packed {
    logic [6:0] page;
    logic [6:0] link;
    status_t    status;
    logic [7:0] free_pages;
    logic [7:0] released;
  } reply_t;

  bit         free_flag [PAGES];
  logic [6:0] link_of [PAGES];
  int         free_total;
  reply_t     replies_due [$];

  function automatic bit walkable_page(int p);
    return p >= END_MARK && p >= FIRST_FREE && p < PAGES;
  endfunction

  function automatic reply_t serve_request(func_t fn, int pg, logic [6:0] lv);
    reply_t r;
    bit     found;
    bit     done;
    int     p;
    int     steps;
    int     nxt;
    r = '0;
    r.status = STAT_OK;
    case (fn)
      FN_ALLOC: begin
        r.status = STAT_NOFREE;
        found = 1'b0;
        for (int i = 0; i < PAGES; i++) begin
          if (!found && free_flag[i]) begin
            found = 1'b1;
            free_flag[i] = 1'b0;
            link_of[i] = '0;
            if (free_total > 0) free_total--;
            r.page = 7'(i);
            r.status = STAT_OK;
          end
        end
      end
      FN_SET: begin
        if (walkable_page(pg)) link_of[pg] = lv;
        else r.status = STAT_RSV;
      end
      FN_READ: begin
        if (pg < PAGES) r.link = link_of[pg];
        else r.status = STAT_RSV;
      end
      default: begin
        if (!walkable_page(pg)) begin
          r.status = STAT_RSV;
        end else begin
          p = pg;
          steps = 0;
          done = 1'b0;
          while (!done) begin
            if (!free_flag[p]) begin
              free_flag[p] = 1'b1;
              free_total++;
              r.released++;
            end
            steps++;
            nxt = link_of[p];
            if (!walkable_page(nxt)) begin
              done = 1'b1;
            end else if (steps >= PAGES) begin
              r.status = STAT_BOUND;
              done = 1'b1;
            end else begin
              p = nxt;
            end
          end
        end
      end
    endcase
    r.free_pages = 8'(free_total);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t: reply %0d %s: got %0d, want %0d", $time, replies_checked, field,
               got, want);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < PAGES; i++) begin
        free_flag[i] = (i >= FIRST_FREE);
        link_of[i] = '0;
      end
      free_total = PAGES - FIRST_FREE;
      replies_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("beat with nothing pending", 1, 0);
        end else begin
          want = replies_due.pop_front();
          if (out_tdata[6:0] !== want.page)
            report_mismatch("result_page", out_tdata[6:0], want.page);
          if (out_tdata[13:7] !== want.link)
            report_mismatch("result_link", out_tdata[13:7], want.link);
          if (out_tdata[15:14] !== want.status)
            report_mismatch("status", out_tdata[15:14], want.status);
          if (out_tdata[23:16] !== want.free_pages)
            report_mismatch("free_pages", out_tdata[23:16], want.free_pages);
          if (out_tdata[31:24] !== want.released)
            report_mismatch("pages_released", out_tdata[31:24], want.released);
        end
        replies_checked++;
        if (out_tdata[15:14] == STAT_BOUND) bound_walks++;
        if (out_tdata[15:14] == STAT_NOFREE) empty_allocs++;
      end
      if (in_tvalid && in_tready)
        replies_due.push_back(serve_request(func_t'(in_tuser), in_tdata[6:0],
                                            in_tdata[13:7]));
    end
    outstanding <= replies_due.size();
  end

endmodule

### sim/page_bitmap_allocator_with_chains_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_with_chains_tb
// Drives allocate, set-link, read-link and chain release beats into the page
// allocator under changing stall patterns; the checker predicts every reply.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_with_chains_tb;
  import pbac_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASE_BEATS  = 450;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;

  int fail_count;
  int outstanding;
  int replies_checked;
  int bound_walks;
  int empty_allocs;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_sent    = 0;
  int quiet_cycles  = 0;

  always #4 clk = ~clk;

  page_bitmap_allocator_with_chains dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  page_alloc_checker page_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .replies_checked (replies_checked),
    .bound_walks     (bound_walks),
    .empty_allocs    (empty_allocs)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no beat accepted for %0d cycles", STALL_LIMIT);
      $display("page_bitmap_allocator_with_chains_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(func_t fn, logic [6:0] pg, logic [6:0] lv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {2'b00, lv, pg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // hold off until every reply is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic alloc_burst(int count);
    repeat (count) issue(FN_ALLOC, 7'($urandom), 7'($urandom));
  endtask

  task automatic run_chain();
    logic [6:0] chain_pg [12];
    logic [6:0] tail;
    int         len;
    int         hi;
    alloc_burst($urandom_range(0, 8));
    len = $urandom_range(1, 12);
    case ($urandom_range(0, 2))
      0:       hi = 20;
      1:       hi = 60;
      default: hi = 127;
    endcase
    for (int i = 0; i < len; i++) chain_pg[i] = 7'($urandom_range(2, hi));
    for (int i = 0; i < len - 1; i++) issue(FN_SET, chain_pg[i], chain_pg[i + 1]);
    case ($urandom_range(0, 9))
      0, 1:    tail = chain_pg[$urandom_range(0, len - 1)];
      2:       tail = 7'($urandom);
      default: tail = 7'($urandom_range(0, 1));
    endcase
    issue(FN_SET, chain_pg[len - 1], tail);
    repeat ($urandom_range(0, 2))
      issue(FN_READ, chain_pg[$urandom_range(0, len - 1)], 7'($urandom));
    if ($urandom_range(0, 9) != 0) issue(FN_RELEASE, chain_pg[0], 7'($urandom));
    else issue(FN_RELEASE, chain_pg[$urandom_range(0, len - 1)], 7'($urandom));
  endtask

  task automatic run_phase(int snd_pct, int rcv_pct, int count);
    int stop;
    int pick;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    stop = beats_sent + count;
    while (beats_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) alloc_burst(130);
      else if (pick < 62) run_chain();
      else issue(func_t'($urandom_range(0, 3)), 7'($urandom), 7'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 50;

    issue(FN_READ, 7'd0, 7'd0);
    issue(FN_READ, 7'd127, 7'd127);
    issue(FN_ALLOC, 7'd0, 7'd0);
    issue(FN_ALLOC, 7'd127, 7'd127);
    issue(FN_SET, 7'd0, 7'd5);
    issue(FN_SET, 7'd1, 7'd5);
    issue(FN_RELEASE, 7'd0, 7'd0);
    issue(FN_RELEASE, 7'd1, 7'd0);
    issue(FN_SET, 7'd127, 7'd127);
    issue(FN_READ, 7'd127, 7'd0);
    issue(FN_SET, 7'd2, 7'd3);
    issue(FN_SET, 7'd3, 7'd1);
    issue(FN_RELEASE, 7'd2, 7'd0);
    issue(FN_RELEASE, 7'd2, 7'd0);
    issue(FN_ALLOC, 7'd0, 7'd0);
    issue(FN_ALLOC, 7'd0, 7'd0);
    issue(FN_READ, 7'd2, 7'd0);
    issue(FN_SET, 7'd10, 7'd11);
    issue(FN_SET, 7'd11, 7'd10);
    issue(FN_RELEASE, 7'd10, 7'd0);
    issue(FN_RELEASE, 7'd127, 7'd0);
    issue(FN_SET, 7'd3, 7'd0);
    issue(FN_RELEASE, 7'd3, 7'd0);
    wait_drained();

    send_idle_pct = 20;
    alloc_burst(130);
    run_phase(20, 50, PHASE_BEATS);
    run_phase(50, 20, PHASE_BEATS);
    run_phase(0, 0, PHASE_BEATS);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d request beats and checked %0d replies over three stall mixes",
             beats_sent, replies_checked);
    $display("%0d release walks stopped at the bound, %0d allocations found no page",
             bound_walks, empty_allocs);
    if (fail_count == 0) begin
      $display("page_bitmap_allocator_with_chains_tb: clean");
    end else begin
      $display("page_bitmap_allocator_with_chains_tb: errors");
    end
    $finish;
  end

endmodule
